// File: rtl/core/tbs_pkg.sv
// Shared types, constants and rotate helper for the timed ban set.
package tbs_pkg;

	localparam int BUCKETS = 1024;
	localparam int SLOTS   = 4;
	localparam int BKT_W   = $clog2(BUCKETS);
	localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic [1:0] ST_HIT     = 2'd0;
	localparam logic [1:0] ST_MISS    = 2'd1;
	localparam logic [1:0] ST_EXPIRED = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	localparam logic [1:0] REG_BAN_TIME = 2'd0;
	localparam logic [1:0] REG_REFRESH  = 2'd1;
	localparam logic [1:0] REG_SEED     = 2'd2;

	localparam logic OP_LOOKUP = 1'b0;

	localparam logic [31:0] HASH_INIT = 32'hdeadbeef + 32'd4;

	typedef struct packed {
		logic        vld;
		logic [31:0] key;
		logic [63:0] stamp;
	} entry_t;

	typedef entry_t [SLOTS-1:0] row_t;

	localparam int ROW_W = $bits(row_t);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH1,
		S_HASH2,
		S_READ,
		S_EVAL
	} state_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic hash1;
		logic hash2;
		logic rd;
		logic eval;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
	} sts_t;

	function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

endpackage

// File: rtl/core/tbs_ram.sv
// Generic simple dual-port RAM with registered read.
module tbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/tbs_ctrl.sv
// Controller state machine: clearing sweep and per-request sequencing.
module tbs_ctrl import tbs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: if (sts.clr_last) state_nxt = S_IDLE;
			S_IDLE:  if (in_valid) state_nxt = S_HASH1;
			S_HASH1: state_nxt = S_HASH2;
			S_HASH2: state_nxt = S_READ;
			S_READ:  state_nxt = S_EVAL;
			S_EVAL:  if (out_free) state_nxt = S_IDLE;
			default: state_nxt = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_CLEAR: cmd.clr = 1'b1;
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			S_HASH1: cmd.hash1 = 1'b1;
			S_HASH2: cmd.hash2 = 1'b1;
			S_READ:  cmd.rd = 1'b1;
			S_EVAL:  cmd.eval = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.eval) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/core/tbs_dp.sv
// Datapath: config registers, hash, bucket memory, slot compare, result register.
module tbs_dp import tbs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        op,
	input  logic [31:0] key,
	input  logic [63:0] now,
	output logic [1:0]  status,
	output logic [1:0]  slot
);

	logic [63:0]      ban_time_q;
	logic             refresh_q;
	logic [31:0]      seed_q;
	logic             op_q;
	logic [31:0]      key_q;
	logic [63:0]      now_q;
	logic [31:0]      a_q, b_q, c_q;
	logic [BKT_W-1:0] bucket_q;
	logic [BKT_W-1:0] clr_cnt_q;
	logic [1:0]       status_q;
	logic [1:0]       slot_q;

	logic [31:0]      a1, b1, c1, a2, b2, c2;
	logic [ROW_W-1:0] rdata;
	row_t             row, row_nxt;
	logic [SLOTS-1:0] match, free;
	logic [SLOT_IW-1:0] m_idx, f_idx;
	logic [1:0]       st_nxt;
	logic [SLOT_IW-1:0] sl_nxt;
	logic [63:0]      age;
	logic             ram_we;
	logic [BKT_W-1:0] waddr;
	logic [ROW_W-1:0] wdata;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ban_time_q <= '0;
			refresh_q  <= 1'b0;
			seed_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BAN_TIME: ban_time_q <= cfg_data;
				REG_REFRESH:  refresh_q  <= cfg_data[0];
				REG_SEED:     seed_q     <= cfg_data[31:0];
				default:      ;
			endcase
		end
	end

	// hash, first four mix steps from the latched key
	always_comb begin
		a1 = HASH_INIT + seed_q + key_q;
		b1 = HASH_INIT + seed_q;
		c1 = HASH_INIT + seed_q;
		c1 = (c1 ^ b1) - rotl32(b1, 14);
		a1 = (a1 ^ c1) - rotl32(c1, 11);
		b1 = (b1 ^ a1) - rotl32(a1, 25);
		c1 = (c1 ^ b1) - rotl32(b1, 16);
	end

	// last three mix steps
	always_comb begin
		a2 = (a_q ^ c_q) - rotl32(c_q, 4);
		b2 = (b_q ^ a2) - rotl32(a2, 14);
		c2 = (c_q ^ b2) - rotl32(b2, 24);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			key_q <= key;
			now_q <= now;
		end
		if (cmd.hash1) begin
			a_q <= a1;
			b_q <= b1;
			c_q <= c1;
		end
		if (cmd.hash2) begin
			bucket_q <= c2[BKT_W-1:0];
		end
		if (cmd.eval) begin
			status_q <= st_nxt;
			slot_q   <= 2'(sl_nxt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign sts.clr_last = (clr_cnt_q == BKT_W'(BUCKETS - 1));

	// slot compare and update
	always_comb begin
		row   = row_t'(rdata);
		m_idx = '0;
		f_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			age      = now_q - row[i].stamp;
			match[i] = row[i].vld && (row[i].key == key_q);
			free[i]  = !row[i].vld || (age > ban_time_q);
		end
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (match[i]) m_idx = SLOT_IW'(i);
			if (free[i])  f_idx = SLOT_IW'(i);
		end
		row_nxt = row;
		st_nxt  = ST_MISS;
		sl_nxt  = '0;
		if (|match) begin
			sl_nxt = m_idx;
			st_nxt = ST_HIT;
			if (op_q != OP_LOOKUP) begin
				row_nxt[m_idx].stamp = now_q;
			end else if (free[m_idx]) begin
				row_nxt[m_idx] = '0;
				st_nxt         = ST_EXPIRED;
			end else if (refresh_q) begin
				row_nxt[m_idx].stamp = now_q;
			end
		end else if (op_q != OP_LOOKUP) begin
			if (|free) begin
				sl_nxt                = f_idx;
				st_nxt                = ST_HIT;
				row_nxt[f_idx].vld    = 1'b1;
				row_nxt[f_idx].key    = key_q;
				row_nxt[f_idx].stamp  = now_q;
			end else begin
				st_nxt = ST_FULL;
			end
		end
	end

	assign ram_we = cmd.clr || cmd.eval;
	assign waddr  = cmd.clr ? clr_cnt_q : bucket_q;
	assign wdata  = cmd.clr ? '0 : ROW_W'(row_nxt);

	tbs_ram #(
		.WIDTH(ROW_W),
		.DEPTH(BUCKETS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd),
		.raddr(bucket_q),
		.rdata(rdata)
	);

	assign status = status_q;
	assign slot   = slot_q;

endmodule

// File: rtl/core/timed_ban_set.sv
// Top level: bucketed hash set of keys with timestamps and expiry.
// Each request runs idle/accept, 2 hash, read, compare/write-back, and the result
// is registered at the compare; the next request is accepted only in idle/accept.
// A result waiting on out_stall holds the next request in the compare step.
// Reset: asynchronous; state and config clear at once, then a sweep over all BUCKETS
// (1024) rows zeroes the bucket memory with in_stall high; config writes work throughout.
module timed_ban_set import tbs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [31:0] key,
	input  logic [63:0] now,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [1:0]  slot
);

	cmd_t cmd;
	sts_t sts;

	// sequencing: clear sweep, hash, read, compare/write-back
	tbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// hash, bucket row memory and the per-slot compare
	tbs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.op       (op),
		.key      (key),
		.now      (now),
		.status   (status),
		.slot     (slot)
	);

endmodule

// File: rtl/core/tbs_chk.sv
// Port-level checker for the timed ban set, bound to the top level.
module tbs_chk import tbs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] status,
	input logic [1:0] slot
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(status) && $stable(slot))
		else $error("stalled result changed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while busy");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_MISS || status == ST_FULL) |-> slot == 2'd0)
		else $error("nonzero slot on miss or full");

endmodule

bind timed_ban_set tbs_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.status   (status),
	.slot     (slot)
);
